// File: hw/rtl/kfmh_pkg.sv
// Package for the key fold multiplicative hash core.
// Holds the transaction payload types, the queue entry type and the hash constants.
// No dependencies; every other file in hw/rtl imports it.
`default_nettype none

package kfmh_pkg;

	// Fold modulus, multiplier of the multiplicative hash and the register reset value.
	localparam logic [31:0] FOLD_Q     = 32'd4294967029;
	localparam logic [31:0] GOLDEN     = 32'd2654435769;
	localparam logic [4:0]  TSL_RESET  = 5'd8;

	// Byte counter: bytes kept in the short word, and the saturation value.
	localparam logic [2:0]  SHORT_BYTES = 3'd4;
	localparam logic [2:0]  COUNT_SAT   = 3'd5;

	// Queue between the fold front and the hash back.
	localparam int          QUEUE_DEPTH = 4;
	localparam int          QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int          QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// One input transaction.
	typedef struct packed {
		logic [7:0] key_byte;
		logic       byte_valid;
		logic       last_byte;
		logic       string_mode;
	} kfmh_in_t;

	// One result transaction.
	typedef struct packed {
		logic [30:0] bucket_index;
		logic [31:0] folded_key;
	} kfmh_out_t;

	// A finished key waiting for the hash back end.
	typedef struct packed {
		logic [31:0] key;
		logic [4:0]  log2_size;
	} kfmh_job_t;

endpackage

`default_nettype wire

// File: hw/rtl/kfmh_front.sv
// Front end: accepts key bytes, folds them and classifies each finished key.
// Holds the table size register and pushes one job per key into the queue.
// Depends on kfmh_pkg.
`default_nettype none

module kfmh_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              key_valid,
	output logic                   key_stall,
	input  wire kfmh_pkg::kfmh_in_t key_item,
	input  wire logic              cfg_wr_en,
	input  wire logic [4:0]        cfg_wr_data,
	input  wire logic              queue_full,
	output logic                   job_push,
	output kfmh_pkg::kfmh_job_t    job
);
	import kfmh_pkg::*;

	logic [31:0] fold_acc_q;
	logic [2:0]  byte_count_q;
	logic [31:0] short_word_q;
	logic [4:0]  table_size_log2_q;

	logic        accept;
	logic [31:0] fold_sum;
	logic [31:0] acc_next;
	logic [2:0]  count_next;
	logic [31:0] word_next;

	// Items are taken whenever the queue has room for a finished key.
	assign key_stall = queue_full;
	assign accept    = key_valid && !queue_full;

	// One fold step: 257*K + byte wraps at 32 bits, then one conditional subtract.
	assign fold_sum = {fold_acc_q[23:0], 8'h00} + fold_acc_q + {24'h0, key_item.key_byte};

	// Running key state after this item.
	always_comb begin
		acc_next   = fold_acc_q;
		count_next = byte_count_q;
		word_next  = short_word_q;
		if (key_item.byte_valid) begin
			acc_next = (fold_sum >= FOLD_Q) ? (fold_sum - FOLD_Q) : fold_sum;
			if (byte_count_q < SHORT_BYTES) begin
				word_next[{byte_count_q[1:0], 3'b000} +: 8] = key_item.key_byte;
			end
			if (byte_count_q < COUNT_SAT) begin
				count_next = byte_count_q + 3'd1;
			end
		end
	end

	// Classify the finished key: short byte keys use the little-endian word.
	always_comb begin
		job.log2_size = table_size_log2_q;
		if (key_item.string_mode || (count_next > SHORT_BYTES)) begin
			job.key = acc_next;
		end else begin
			job.key = word_next;
		end
	end

	assign job_push = accept && key_item.last_byte;

	// Key state registers; cleared after every finished key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_acc_q   <= '0;
			byte_count_q <= '0;
			short_word_q <= '0;
		end else if (accept) begin
			if (key_item.last_byte) begin
				fold_acc_q   <= '0;
				byte_count_q <= '0;
				short_word_q <= '0;
			end else begin
				fold_acc_q   <= acc_next;
				byte_count_q <= count_next;
				short_word_q <= word_next;
			end
		end
	end

	// Table size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_log2_q <= TSL_RESET;
		end else if (cfg_wr_en) begin
			table_size_log2_q <= cfg_wr_data;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/kfmh_queue.sv
// Short job queue between the fold front end and the hash back end.
// A small register file with read and write pointers and an occupancy count.
// Depends on kfmh_pkg.
`default_nettype none

module kfmh_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire kfmh_pkg::kfmh_job_t push_job,
	output logic                    full,
	output logic                    not_empty,
	input  wire logic               pop,
	output kfmh_pkg::kfmh_job_t     pop_job
);
	import kfmh_pkg::*;

	kfmh_job_t             entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;

	assign full      = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_job   = entry_q[rd_ptr_q];

	// Entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CW'(1);
			end
		end
	end

	// The front end never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("kfmh_queue: push while full");

	// Occupancy never exceeds the depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_CW'(QUEUE_DEPTH))
		else $error("kfmh_queue: occupancy above depth");

	// A lone push grows the occupancy by exactly one.
	a_count_push: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && $past(push && !pop)) |-> count_q == $past(count_q) + QUEUE_CW'(1))
		else $error("kfmh_queue: occupancy did not follow a push");

	// A lone pop shrinks the occupancy by exactly one.
	a_count_pop: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && $past(pop && !push)) |-> count_q == $past(count_q) - QUEUE_CW'(1))
		else $error("kfmh_queue: occupancy did not follow a pop");

endmodule

`default_nettype wire

// File: hw/rtl/kfmh_back.sv
// Back end: multiplicative hash of a finished key and reduction to a bucket.
// Stage 1 multiplies by the golden constant; stage 2 is the output register.
// Depends on kfmh_pkg.
`default_nettype none

module kfmh_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               job_avail,
	input  wire kfmh_pkg::kfmh_job_t job,
	output logic                    job_pop,
	output logic                    hash_valid,
	input  wire logic               hash_stall,
	output kfmh_pkg::kfmh_out_t     hash_result
);
	import kfmh_pkg::*;

	logic        valid_s1;
	logic [31:0] prod_s1;
	logic [31:0] key_s1;
	logic [4:0]  log2_size_s1;
	logic        valid_s2;
	kfmh_out_t   result_s2;

	logic        ready_s2;
	logic        ready_s1;
	logic [31:0] prod;
	logic [5:0]  shift_amt;
	logic [31:0] top_bits;
	logic [31:0] bucket_mask;
	logic [30:0] bucket;

	// Pipeline flow control: each stage loads when it is empty or drains.
	assign ready_s2 = !valid_s2 || !hash_stall;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign job_pop  = job_avail && ready_s1;

	// Low 32 bits of the key times the golden constant.
	assign prod = job.key * GOLDEN;

	// Top m bits of the product; reduce mod 2^m - 1, where only the all-ones value wraps.
	assign shift_amt   = 6'd32 - {1'b0, log2_size_s1};
	assign top_bits    = prod_s1 >> shift_amt;
	assign bucket_mask = (32'd1 << log2_size_s1) - 32'd1;
	always_comb begin
		if ((log2_size_s1 == 5'd0) || (top_bits == bucket_mask)) begin
			bucket = '0;
		end else begin
			bucket = top_bits[30:0];
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= job_avail;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			prod_s1      <= prod;
			key_s1       <= job.key;
			log2_size_s1 <= job.log2_size;
		end
		if (ready_s2 && valid_s1) begin
			result_s2.bucket_index <= bucket;
			result_s2.folded_key   <= key_s1;
		end
	end

	assign hash_valid  = valid_s2;
	assign hash_result = result_s2;

endmodule

`default_nettype wire

// File: hw/rtl/key_fold_multiplicative_hash_core.sv
// Key fold multiplicative hash core: key bytes in, one bucket transaction per key out.
// A finished key passes the job queue, stage 1 and stage 2. Throughput: one byte per
// cycle unless the queue is full; the four-entry job queue plus the back pipeline let
// the front keep taking bytes while a result waits on a stalled output.
// Reset clears the key state, the queue and the pipeline, and sets the table size to 8.
// Depends on kfmh_pkg, kfmh_front, kfmh_queue and kfmh_back.
`default_nettype none

module key_fold_multiplicative_hash_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               key_valid,
	output logic                    key_stall,
	input  wire kfmh_pkg::kfmh_in_t key_item,
	output logic                    hash_valid,
	input  wire logic               hash_stall,
	output kfmh_pkg::kfmh_out_t     hash_result,
	input  wire logic               cfg_wr_en,
	input  wire logic [4:0]         cfg_wr_data
);
	import kfmh_pkg::*;

	logic      queue_full;
	logic      queue_not_empty;
	logic      job_push;
	logic      job_pop;
	kfmh_job_t push_job;
	kfmh_job_t pop_job;

	// Byte intake, fold and key classification.
	kfmh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_valid  (key_valid),
		.key_stall  (key_stall),
		.key_item   (key_item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.queue_full (queue_full),
		.job_push   (job_push),
		.job        (push_job)
	);

	// Finished keys waiting for the hash.
	kfmh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.full     (queue_full),
		.not_empty(queue_not_empty),
		.pop      (job_pop),
		.pop_job  (pop_job)
	);

	// Multiplicative hash and bucket reduction.
	kfmh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_avail  (queue_not_empty),
		.job        (pop_job),
		.job_pop    (job_pop),
		.hash_valid (hash_valid),
		.hash_stall (hash_stall),
		.hash_result(hash_result)
	);

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for key_fold_multiplicative_hash_core.
// Drives key bytes and table size writes, predicts the bucket transactions and checks them.
// Depends on kfmh_pkg and the core RTL only.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kfmh_pkg::*;

	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int CFG_SETTLE     = 8;
	localparam int DRAIN_CYCLES   = 10;
	localparam int NUM_PHASES     = 9;
	localparam int PHASE_ITEMS    = 160;
	localparam int SCRIPT_ROWS    = 25;

	// One row of the directed key script; a known value overrides the prediction.
	typedef struct packed {
		logic [7:0]  kb;
		logic        v;
		logic        l;
		logic        s;
		logic        fk_known;
		logic [31:0] fk;
		logic        bk_known;
		logic [30:0] bk;
	} key_row_t;

	logic       clk;
	logic       arst_n;
	logic       key_valid;
	logic       key_stall;
	kfmh_in_t   key_item;
	logic       hash_valid;
	logic       hash_stall;
	kfmh_out_t  hash_result;
	logic       cfg_wr_en;
	logic [4:0] cfg_wr_data;

	// Predicted key state and table size.
	logic [31:0] acc_key    = '0;
	logic [31:0] short_key  = '0;
	logic [2:0]  bytes_seen = '0;
	logic [4:0]  size_log2  = TSL_RESET;

	kfmh_out_t expected_hashes [$];
	key_row_t  key_script [SCRIPT_ROWS];
	int        mismatches  = 0;
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;
	logic      hold_go;

	key_fold_multiplicative_hash_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_valid  (key_valid),
		.key_stall  (key_stall),
		.key_item   (key_item),
		.hash_valid (hash_valid),
		.hash_stall (hash_stall),
		.hash_result(hash_result),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// Fold one transaction into the predicted key; a final transaction yields the bucket.
	task automatic absorb_item(input kfmh_in_t it, output bit done, output kfmh_out_t r);
		logic [31:0] s;
		logic [31:0] k;
		logic [31:0] prod;
		logic [31:0] h;
		logic [31:0] modv;
		done = 1'b0;
		r = '0;
		if (it.byte_valid) begin
			s = acc_key * 32'd257;
			s = s + {24'd0, it.key_byte};
			acc_key = s % FOLD_Q;
			if (bytes_seen < SHORT_BYTES)
				short_key = short_key | ({24'd0, it.key_byte} << (8 * bytes_seen));
			if (bytes_seen < COUNT_SAT)
				bytes_seen = bytes_seen + 3'd1;
		end
		if (it.last_byte) begin
			k = (it.string_mode || bytes_seen > SHORT_BYTES) ? acc_key : short_key;
			prod = k * GOLDEN;
			h = '0;
			if (size_log2 != 5'd0) begin
				modv = (32'd1 << size_log2) - 32'd1;
				h = (prod >> (32 - size_log2)) % modv;
			end
			r.folded_key = k;
			r.bucket_index = h[30:0];
			done = 1'b1;
			acc_key = '0;
			short_key = '0;
			bytes_seen = '0;
		end
	endtask

	// Offer one transaction, wait for it to be taken and record the prediction.
	task automatic send_item(input kfmh_in_t it);
		bit        done;
		kfmh_out_t r;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			key_valid <= 1'b0;
			@(posedge clk);
		end
		key_item <= it;
		key_valid <= 1'b1;
		@(posedge clk);
		while (key_stall)
			@(posedge clk);
		absorb_item(it, done, r);
		if (done)
			expected_hashes.push_back(r);
	endtask

	// Wait until the core has drained, then write the table size.
	task automatic write_size(input logic [4:0] m);
		key_valid <= 1'b0;
		@(posedge clk);
		while (expected_hashes.size() != 0)
			@(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		size_log2 = m;
	endtask

	// A random key: mostly well formed, with ignored transactions mixed in and
	// sometimes ended by a final transaction that carries no byte.
	task automatic send_random_key(output int counted);
		int       len;
		int       r;
		bit       mode;
		bit       split_end;
		kfmh_in_t it;
		r = $urandom_range(0, 99);
		if (r < 5)
			len = 0;
		else if (r < 70)
			len = $urandom_range(1, 4);
		else if (r < 92)
			len = $urandom_range(5, 8);
		else
			len = $urandom_range(9, 24);
		mode = 1'($urandom_range(0, 1));
		split_end = ($urandom_range(0, 5) == 0);
		counted = 0;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 11) == 0) begin
				it.key_byte = 8'($urandom_range(0, 255));
				it.byte_valid = 1'b0;
				it.last_byte = 1'b0;
				it.string_mode = 1'($urandom_range(0, 1));
				send_item(it);
				counted++;
			end
			r = $urandom_range(0, 7);
			it.key_byte = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom_range(0, 255));
			it.byte_valid = 1'b1;
			it.last_byte = (i == len - 1) && !split_end;
			it.string_mode = it.last_byte ? mode : 1'($urandom_range(0, 1));
			send_item(it);
			counted++;
		end
		if (len == 0 || split_end) begin
			it.key_byte = 8'($urandom_range(0, 255));
			it.byte_valid = 1'b0;
			it.last_byte = 1'b1;
			it.string_mode = mode;
			send_item(it);
			counted++;
		end
	endtask

	// Output side: random stall, plus one long hold-off on request.
	initial begin
		int  hold_left;
		bit  hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		hash_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				hash_stall <= 1'b1;
			end else begin
				hash_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			end
		end
	end

	// Check every accepted result transaction against the oldest prediction.
	always @(posedge clk) begin
		kfmh_out_t want;
		if (arst_n && hash_valid && !hash_stall) begin
			if (expected_hashes.size() == 0) begin
				report_mismatch("result with none expected", hash_result, '0);
			end else begin
				want = expected_hashes.pop_front();
				if (hash_result.bucket_index !== want.bucket_index)
					report_mismatch("bucket_index", hash_result.bucket_index,
						want.bucket_index);
				if (hash_result.folded_key !== want.folded_key)
					report_mismatch("folded_key", hash_result.folded_key, want.folded_key);
			end
		end
	end

	// Watchdog: cycles with no transaction on either side.
	always @(posedge clk) begin
		int quiet;
		if (!arst_n || (key_valid && !key_stall) || (hash_valid && !hash_stall)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Main stimulus: directed keys, then random phases over table sizes and idle mixes.
	initial begin
		kfmh_in_t   it;
		kfmh_out_t  want;
		int         n;
		int         sent;
		bit         paused;
		logic [4:0] phase_sizes [NUM_PHASES];
		arst_n <= 1'b0;
		key_valid <= 1'b0;
		key_item <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		hold_go <= 1'b0;
		paused = 1'b0;
		phase_sizes = '{5'd1, 5'd31, 5'd8, 5'd31, 5'd2, 5'd17, 5'd1, 5'd30, 5'd31};
		phase_sizes[5] = 5'($urandom_range(3, 29));
		key_script = '{
			// Empty keys in both modes.
			'{8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 32'h0, 1'b1, 31'd0},
			'{8'h5a, 1'b0, 1'b1, 1'b1, 1'b1, 32'h0, 1'b1, 31'd0},
			// Single byte keys; a zero byte in string mode folds to zero.
			'{8'hff, 1'b1, 1'b1, 1'b0, 1'b1, 32'hff, 1'b0, 31'd0},
			'{8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 32'h0, 1'b1, 31'd0},
			// Four byte key with an ignored transaction inside.
			'{8'h01, 1'b1, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, 31'd0},
			'{8'h02, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 31'd0},
			'{8'haa, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, 31'd0},
			'{8'h03, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 31'd0},
			'{8'h04, 1'b1, 1'b1, 1'b0, 1'b1, 32'h04030201, 1'b0, 31'd0},
			// All ones short word.
			'{8'hff, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 31'd0},
			'{8'hff, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 31'd0},
			'{8'hff, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 31'd0},
			'{8'hff, 1'b1, 1'b1, 1'b0, 1'b1, 32'hffffffff, 1'b0, 31'd0},
			// Five byte key in byte mode falls back to the fold.
			'{8'h11, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 31'd0},
			'{8'h22, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 31'd0},
			'{8'h33, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 31'd0},
			'{8'h44, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 31'd0},
			'{8'h55, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 31'd0},
			// Mode is taken from the final transaction only.
			'{8'h80, 1'b1, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, 31'd0},
			'{8'h7f, 1'b1, 1'b1, 1'b0, 1'b1, 32'h7f80, 1'b0, 31'd0},
			// Keys ended by a final transaction without a byte.
			'{8'hab, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 31'd0},
			'{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'hab, 1'b0, 31'd0},
			'{8'hfe, 1'b1, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, 31'd0},
			'{8'hff, 1'b0, 1'b1, 1'b0, 1'b1, 32'hfe, 1'b0, 31'd0},
			// String key of one all ones byte.
			'{8'hff, 1'b1, 1'b1, 1'b1, 1'b1, 32'hff, 1'b0, 31'd0}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed keys at the reset table size.
		for (int i = 0; i < SCRIPT_ROWS; i++) begin
			it = '{key_script[i].kb, key_script[i].v, key_script[i].l, key_script[i].s};
			send_item(it);
			if (key_script[i].fk_known) begin
				want = expected_hashes.pop_back();
				want.folded_key = key_script[i].fk;
				if (key_script[i].bk_known)
					want.bucket_index = key_script[i].bk;
				expected_hashes.push_back(want);
			end
		end

		// Random phases: three idle mixes, each over several table sizes.
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_size(phase_sizes[p]);
			case (p / 3)
				0: begin
					tx_idle_pct = 31;
					rx_idle_pct <= 66;
				end
				1: begin
					tx_idle_pct = 66;
					rx_idle_pct <= 31;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct <= 0;
				end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (p == 6 && sent == 0)
					hold_go <= 1'b1;
				if (p == 7 && !paused && sent >= PHASE_ITEMS / 2) begin
					// Let the core drain completely before going on.
					paused = 1'b1;
					key_valid <= 1'b0;
					@(posedge clk);
					while (expected_hashes.size() != 0)
						@(posedge clk);
				end
				send_random_key(n);
				sent += n;
			end
		end

		key_valid <= 1'b0;
		@(posedge clk);
		while (expected_hashes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

// File: key_fold_multiplicative_hash_core.f
hw/rtl/kfmh_pkg.sv
hw/rtl/kfmh_front.sv
hw/rtl/kfmh_queue.sv
hw/rtl/kfmh_back.sv
hw/rtl/key_fold_multiplicative_hash_core.sv
verif/tb.sv
